[hw/rtl/thc_pkg.sv]
// Shared types and constants for the thermostat hysteresis controller.
// No dependencies; every other file in hw/rtl refers to this package.
`default_nettype none

package thc_pkg;

   localparam int SampleWidth = 12;
   localparam int GapWidth    = 8;
   localparam int SumWidth    = 15;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   // Register indexes on the configuration port (byte address is 4 * index).
   localparam logic [2:0] REG_TARGET_TEMP    = 3'd0;
   localparam logic [2:0] REG_HEAT_START_GAP = 3'd1;
   localparam logic [2:0] REG_STOP_GAP       = 3'd2;
   localparam logic [2:0] REG_COOL_START_GAP = 3'd3;
   localparam logic [2:0] REG_MISMATCH_LIMIT = 3'd4;

   localparam logic signed [SampleWidth-1:0] TARGET_TEMP_RESET    = 12'sd416;
   localparam logic [GapWidth-1:0]           HEAT_START_GAP_RESET = 8'd8;
   localparam logic [GapWidth-1:0]           STOP_GAP_RESET       = 8'd8;
   localparam logic [GapWidth-1:0]           COOL_START_GAP_RESET = 8'd16;
   localparam logic [GapWidth-1:0]           MISMATCH_LIMIT_RESET = 8'd8;

   // Bias that makes the three-sample sum non-negative before the divide by three.
   localparam logic signed [SumWidth-1:0] SUM_BIAS = 15'sd6144;
   // (2^17 + 1) / 3: exact floor(x / 3) as (x * DIV3_RECIP) >> 17 for x < 2^17.
   localparam logic [15:0] DIV3_RECIP = 16'd43691;
   localparam int          DIV3_SHIFT = 17;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample_a;
      logic signed [SampleWidth-1:0] sample_b;
      logic signed [SampleWidth-1:0] sample_c;
   } sample_type;

   typedef struct packed {
      logic                          heater_on;
      logic                          cooler_on;
      logic                          sensor_mismatch;
      logic signed [SampleWidth-1:0] average_temp;
   } result_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] target_temp;
      logic [GapWidth-1:0]           heat_start_gap;
      logic [GapWidth-1:0]           stop_gap;
      logic [GapWidth-1:0]           cool_start_gap;
      logic [GapWidth-1:0]           mismatch_limit;
   } cfg_type;

   typedef struct packed {
      logic heater;
      logic cooler;
   } flags_type;

endpackage

`default_nettype wire

[hw/rtl/thc_req_if.sv]
// Input channel of the thermostat controller: one round of three readings.
// Depends on thc_pkg for the sample width.
`default_nettype none

interface thc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [thc_pkg::SampleWidth-1:0] sample_a;
   logic signed [thc_pkg::SampleWidth-1:0] sample_b;
   logic signed [thc_pkg::SampleWidth-1:0] sample_c;

   modport source (output valid, output sample_a, output sample_b, output sample_c,
                   input ready);
   modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/thc_rsp_if.sv]
// Result channel of the thermostat controller: flags and average per round.
// Depends on thc_pkg for the sample width.
`default_nettype none

interface thc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   heater_on;
   logic                                   cooler_on;
   logic                                   sensor_mismatch;
   logic signed [thc_pkg::SampleWidth-1:0] average_temp;

   modport source (output valid, output heater_on, output cooler_on,
                   output sensor_mismatch, output average_temp, input ready);
   modport sink   (input valid, input heater_on, input cooler_on,
                   input sensor_mismatch, input average_temp, output ready);
endinterface

`default_nettype wire

[hw/rtl/thermostat_hysteresis_controller.sv]
// Top level of the thermostat hysteresis controller: input register,
// evaluation logic, result register and configuration registers.
// Depends on thc_pkg, thc_req_if, thc_rsp_if, thc_csr and thc_eval.
//
//   Channel  Port                 Direction  Content
//   req      req_ch (sink)        in         sample_a, sample_b, sample_c
//   rsp      rsp_ch (source)      out        heater_on, cooler_on, sensor_mismatch,
//                                            average_temp
//   csr      csr_* (APB-style)    in/out     five configuration registers
//
// A round is registered in the input register on its transfer and its result
// in the result register as it advances; one round per cycle is sustained
// while rsp is not stalled. The heater and cooler flags are updated as a round
// moves into the result register. A stalled result holds the result register
// while the input register still takes one more round. Reset clears both flags,
// both valid bits and restores the configuration reset values.
`default_nettype none

module thermostat_hysteresis_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   thc_req_if.sink                                req_ch,
   thc_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [thc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [thc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic      [thc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   thc_pkg::cfg_type    cfg;
   thc_pkg::sample_type samp_ff;
   thc_pkg::sample_type samp_in;
   logic                samp_valid_ff;
   logic                samp_valid_in;
   thc_pkg::result_type rsp_data_ff;
   thc_pkg::result_type rsp_data_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   thc_pkg::flags_type  flags_ff;
   thc_pkg::flags_type  flags_in;
   thc_pkg::flags_type  flags_next;
   thc_pkg::result_type result;
   logic                advance;
   logic                take;

   thc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   thc_eval u_eval (
      .samp       (samp_ff),
      .cfg        (cfg),
      .flags      (flags_ff),
      .flags_next (flags_next),
      .result     (result)
   );

   // A round leaves the input register when the result register is free or
   // being emptied in the same cycle.
   assign advance      = samp_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !samp_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      samp_in.sample_a = req_ch.sample_a;
      samp_in.sample_b = req_ch.sample_b;
      samp_in.sample_c = req_ch.sample_c;
      samp_valid_in    = take || (samp_valid_ff && !advance);
      rsp_valid_in     = advance || (rsp_valid_ff && !rsp_ch.ready);
      rsp_data_in      = result;
      flags_in         = advance ? flags_next : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '0;
      end else begin
         samp_valid_ff <= samp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         flags_ff      <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         samp_ff <= samp_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.heater_on       = rsp_data_ff.heater_on;
   assign rsp_ch.cooler_on       = rsp_data_ff.cooler_on;
   assign rsp_ch.sensor_mismatch = rsp_data_ff.sensor_mismatch;
   assign rsp_ch.average_temp    = rsp_data_ff.average_temp;

endmodule

`default_nettype wire

[hw/rtl/thc_csr.sv]
// Configuration register file behind an APB-style port.
// Depends on thc_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module thc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [thc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [thc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic      [thc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output thc_pkg::cfg_type                       cfg
);

   thc_pkg::cfg_type cfg_ff;
   thc_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            thc_pkg::REG_TARGET_TEMP:    cfg_in.target_temp    = csr_pwdata[11:0];
            thc_pkg::REG_HEAT_START_GAP: cfg_in.heat_start_gap = csr_pwdata[7:0];
            thc_pkg::REG_STOP_GAP:       cfg_in.stop_gap       = csr_pwdata[7:0];
            thc_pkg::REG_COOL_START_GAP: cfg_in.cool_start_gap = csr_pwdata[7:0];
            thc_pkg::REG_MISMATCH_LIMIT: cfg_in.mismatch_limit = csr_pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp    <= thc_pkg::TARGET_TEMP_RESET;
         cfg_ff.heat_start_gap <= thc_pkg::HEAT_START_GAP_RESET;
         cfg_ff.stop_gap       <= thc_pkg::STOP_GAP_RESET;
         cfg_ff.cool_start_gap <= thc_pkg::COOL_START_GAP_RESET;
         cfg_ff.mismatch_limit <= thc_pkg::MISMATCH_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         thc_pkg::REG_TARGET_TEMP:
            csr_prdata = {{20{cfg_ff.target_temp[11]}}, cfg_ff.target_temp};
         thc_pkg::REG_HEAT_START_GAP: csr_prdata = {24'd0, cfg_ff.heat_start_gap};
         thc_pkg::REG_STOP_GAP:       csr_prdata = {24'd0, cfg_ff.stop_gap};
         thc_pkg::REG_COOL_START_GAP: csr_prdata = {24'd0, cfg_ff.cool_start_gap};
         thc_pkg::REG_MISMATCH_LIMIT: csr_prdata = {24'd0, cfg_ff.mismatch_limit};
         default:                     csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/thc_eval.sv]
// Per-round evaluation: sum, average, mismatch check and hysteresis decisions.
// Purely combinational; depends on thc_pkg for types and the divide constants.
`default_nettype none

module thc_eval (
   input  wire thc_pkg::sample_type samp,
   input  wire thc_pkg::cfg_type    cfg,
   input  wire thc_pkg::flags_type  flags,
   output thc_pkg::flags_type  flags_next,
   output thc_pkg::result_type result
);

   localparam int SW = thc_pkg::SumWidth;

   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] tgt;
   logic signed [SW-1:0] heat_base;
   logic signed [SW-1:0] stop_base;
   logic signed [SW-1:0] cool_base;
   logic signed [SW-1:0] heat_lvl;
   logic signed [SW-1:0] stop_lvl;
   logic signed [SW-1:0] cool_lvl;
   logic signed [SW-1:0] biased;
   logic [29:0]          prod;
   logic [11:0]          quot;
   logic [11:0]          d_ab;
   logic [11:0]          d_ac;
   logic [11:0]          d_bc;
   logic                 heater;
   logic                 cooler;

   function automatic logic [11:0] abs_diff(input logic signed [11:0] x,
                                             input logic signed [11:0] y);
      logic signed [12:0] d;
      d = 13'(x) - 13'(y);
      abs_diff = d[12] ? 12'(-d) : d[11:0];
   endfunction

   always_comb begin
      sum = SW'(samp.sample_a) + SW'(samp.sample_b) + SW'(samp.sample_c);
      tgt = SW'(cfg.target_temp);

      heat_base = tgt - $signed({7'd0, cfg.heat_start_gap});
      stop_base = tgt + $signed({7'd0, cfg.stop_gap});
      cool_base = tgt + $signed({7'd0, cfg.cool_start_gap});
      // Times three as shift and add; the thresholds stay inside 15 bits signed.
      heat_lvl = (heat_base <<< 1) + heat_base;
      stop_lvl = (stop_base <<< 1) + stop_base;
      cool_lvl = (cool_base <<< 1) + cool_base;

      heater = flags.heater;
      if (sum <= heat_lvl) begin
         heater = 1'b1;
      end else if (sum >= stop_lvl) begin
         heater = 1'b0;
      end
      cooler = flags.cooler;
      if (sum >= cool_lvl) begin
         cooler = 1'b1;
      end else if (sum <= stop_lvl) begin
         cooler = 1'b0;
      end
      if (cooler) begin
         heater = 1'b0;
      end

      // Floor division by three on the biased, non-negative sum; removing the
      // bias of 2048 from a 12-bit quotient is an inversion of its top bit.
      biased = sum + thc_pkg::SUM_BIAS;
      prod   = 30'(biased[13:0]) * 30'(thc_pkg::DIV3_RECIP);
      quot   = prod[thc_pkg::DIV3_SHIFT +: 12];

      d_ab = abs_diff(samp.sample_a, samp.sample_b);
      d_ac = abs_diff(samp.sample_a, samp.sample_c);
      d_bc = abs_diff(samp.sample_b, samp.sample_c);

      flags_next.heater      = heater;
      flags_next.cooler      = cooler;
      result.heater_on       = heater;
      result.cooler_on       = cooler;
      result.sensor_mismatch = (d_ab > {4'd0, cfg.mismatch_limit})
                            || (d_ac > {4'd0, cfg.mismatch_limit})
                            || (d_bc > {4'd0, cfg.mismatch_limit});
      result.average_temp    = {~quot[11], quot[10:0]};
   end

endmodule

`default_nettype wire
